// ----- rtl/cone_isolation_ring_sums_assert.svh -----
// Assertion macros for the cone isolation ring sums block.
// Used inside modules that have clk and rst_n in scope; no other dependencies.
`ifndef CONE_ISOLATION_RING_SUMS_ASSERT_SVH
`define CONE_ISOLATION_RING_SUMS_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define CIRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cirs_pkg.sv -----
// Shared types, constants and helper functions for the cone isolation ring sums block.
// No dependencies; used by every module under rtl.
`default_nettype none

package cirs_pkg;

    // Field widths
    localparam int PT_BITS     = 16;
    localparam int ETA_BITS    = 14;
    localparam int PHI_BITS    = 13;
    localparam int CHARGE_BITS = 3;
    localparam int CFG_BITS    = 16;
    localparam int CNT_BITS    = 12;
    localparam int SUM_BITS    = 24;
    localparam int NUM_WIN     = 6;
    localparam int WIN_BITS    = 3;

    // Geometry widths: deltas grow by one bit, squared distance is twice the eta delta
    localparam int DETA_BITS = ETA_BITS + 1;
    localparam int DPHI_BITS = PHI_BITS + 1;
    localparam int D2_BITS   = 2 * DETA_BITS;

    // Selection and wrap constants (eta/phi in 1/1024, pt in quarter GeV)
    localparam int ETA_MAX    = 2560;
    localparam int PHI_HALF   = 3217;
    localparam int PHI_FULL   = 6434;
    localparam logic [PT_BITS-1:0] LEP_MIN_PT = PT_BITS'(40);

    // Squared ring radii, floor(r*r*2^20)
    localparam logic [D2_BITS-1:0] T01 = D2_BITS'(10485);
    localparam logic [D2_BITS-1:0] T02 = D2_BITS'(41943);
    localparam logic [D2_BITS-1:0] T03 = D2_BITS'(94371);
    localparam logic [D2_BITS-1:0] T04 = D2_BITS'(167772);
    localparam logic [D2_BITS-1:0] T07 = D2_BITS'(513802);
    localparam logic [D2_BITS-1:0] T08 = D2_BITS'(671088);

    localparam logic [WIN_BITS-1:0] LAST_WIN = WIN_BITS'(NUM_WIN - 1);
    localparam logic [CNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [SUM_BITS-1:0] SUM_MAX  = '1;

    typedef enum logic [1:0] {
        FUNC_BEGIN  = 2'd0,
        FUNC_CAND   = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [0:0] {
        CFG_MIN_PT       = 1'b0,
        CFG_CHARGED_ONLY = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [PT_BITS-1:0] min_pt;
        logic               charged_only;
    } cfg_t;

    // Item after the geometry stage
    typedef struct packed {
        func_t              func;
        logic [PT_BITS-1:0] pt;
        logic               keep;
        logic [D2_BITS-1:0] d2;
    } geom_t;

    // Accumulator snapshot handed to the result serialiser
    typedef struct packed {
        logic                              ok;
        logic [NUM_WIN-1:0][CNT_BITS-1:0]  counts;
        logic [NUM_WIN-1:0][SUM_BITS-1:0]  sums;
    } snap_t;

    // Ring membership, strict edges: inside r <=> d2 <= T
    function automatic logic [NUM_WIN-1:0] win_hits(input logic [D2_BITS-1:0] d2);
        logic [NUM_WIN-1:0] h;
        h[0] = (d2 <= T03);
        h[1] = (d2 <= T04);
        h[2] = (d2 > T03) && (d2 <= T07);
        h[3] = (d2 > T04) && (d2 <= T08);
        h[4] = (d2 > T01) && (d2 <= T08);
        h[5] = (d2 > T02) && (d2 <= T08);
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cone_isolation_ring_sums.sv -----
// Cone isolation ring sums: top level with configuration registers.
// A finish passes the input, accumulator and snapshot registers, then one window per cycle
// goes out while out_ready is high; begin and candidate items give none. One item per
// cycle passes input register, geometry and accumulator stages unless a finish waits on
// the serialiser (six transfers per finish). Reset clears lepton, rings and config.
`default_nettype none

module cone_isolation_ring_sums (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [1:0]                              func,
    input  wire logic [cirs_pkg::PT_BITS-1:0]            pt,
    input  wire logic signed [cirs_pkg::ETA_BITS-1:0]    eta,
    input  wire logic signed [cirs_pkg::PHI_BITS-1:0]    phi,
    input  wire logic                                    is_candidate,
    input  wire logic                                    has_charge,
    input  wire logic signed [cirs_pkg::CHARGE_BITS-1:0] charge,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [cirs_pkg::WIN_BITS-1:0]                window,
    output logic [cirs_pkg::CNT_BITS-1:0]                count,
    output logic [cirs_pkg::SUM_BITS-1:0]                sum_pt,
    output logic                                         lepton_passed,
    output logic                                         last,
    input  wire logic                                    cfg_we,
    input  wire logic [0:0]                              cfg_index,
    input  wire logic [cirs_pkg::CFG_BITS-1:0]           cfg_data
);

    cirs_pkg::cfg_t   cfg_reg, cfg_next;
    cirs_pkg::geom_t  geom;
    cirs_pkg::snap_t  snap;
    logic             geom_valid;
    logic             take;
    logic             snap_load;
    logic             emit_free;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cirs_pkg::cfg_idx_t'(cfg_index))
                cirs_pkg::CFG_MIN_PT:       cfg_next.min_pt       = cfg_data[cirs_pkg::PT_BITS-1:0];
                cirs_pkg::CFG_CHARGED_ONLY: cfg_next.charged_only = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cirs_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .pt           (pt),
        .eta          (eta),
        .phi          (phi),
        .is_candidate (is_candidate),
        .has_charge   (has_charge),
        .charge       (charge),
        .cfg          (cfg_reg),
        .take         (take),
        .geom_valid   (geom_valid),
        .geom         (geom)
    );

    cirs_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom_valid (geom_valid),
        .geom       (geom),
        .take       (take),
        .emit_free  (emit_free),
        .snap_load  (snap_load),
        .snap       (snap)
    );

    cirs_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (snap_load),
        .snap          (snap),
        .free          (emit_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window        (window),
        .count         (count),
        .sum_pt        (sum_pt),
        .lepton_passed (lepton_passed),
        .last          (last)
    );

endmodule

`default_nettype wire

// ----- rtl/cirs_geom.sv -----
// Input register and geometry stage: candidate selection, delta eta / wrapped delta phi,
// squared distance. Holds the lepton position. Depends on cirs_pkg.
`default_nettype none

module cirs_geom (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            func,
    input  wire logic [cirs_pkg::PT_BITS-1:0]          pt,
    input  wire logic signed [cirs_pkg::ETA_BITS-1:0]  eta,
    input  wire logic signed [cirs_pkg::PHI_BITS-1:0]  phi,
    input  wire logic                                  is_candidate,
    input  wire logic                                  has_charge,
    input  wire logic signed [cirs_pkg::CHARGE_BITS-1:0] charge,
    input  wire cirs_pkg::cfg_t                        cfg,
    input  wire logic                                  take,
    output logic                                       geom_valid,
    output cirs_pkg::geom_t                            geom
);

    // Input register
    logic                                   a_valid_reg, a_valid_next;
    cirs_pkg::func_t                        a_func_reg;
    logic [cirs_pkg::PT_BITS-1:0]           a_pt_reg;
    logic signed [cirs_pkg::ETA_BITS-1:0]   a_eta_reg;
    logic signed [cirs_pkg::PHI_BITS-1:0]   a_phi_reg;
    logic                                   a_is_cand_reg;
    logic                                   a_has_charge_reg;
    logic signed [cirs_pkg::CHARGE_BITS-1:0] a_charge_reg;

    // Lepton position
    logic signed [cirs_pkg::ETA_BITS-1:0]   lep_eta_reg, lep_eta_next;
    logic signed [cirs_pkg::PHI_BITS-1:0]   lep_phi_reg, lep_phi_next;

    logic                                   in_xfer;
    logic                                   advance;
    logic                                   keep;
    logic signed [cirs_pkg::DETA_BITS-1:0]  deta;
    logic signed [cirs_pkg::DPHI_BITS-1:0]  dphi_raw;
    logic signed [cirs_pkg::DPHI_BITS-1:0]  dphi;
    logic signed [cirs_pkg::D2_BITS-1:0]    deta_w;
    logic signed [2*cirs_pkg::DPHI_BITS-1:0] dphi_w;
    logic signed [cirs_pkg::D2_BITS-1:0]    sq_eta;
    logic signed [2*cirs_pkg::DPHI_BITS-1:0] sq_phi;

    // Handshake
    assign advance    = a_valid_reg && take;
    assign in_ready   = !a_valid_reg || take;
    assign in_xfer    = in_valid && in_ready;
    assign geom_valid = a_valid_reg;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_xfer)
        begin
            a_valid_next = 1'b1;
        end
        else if (advance)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // Payload capture on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_func_reg       <= cirs_pkg::func_t'(func);
            a_pt_reg         <= pt;
            a_eta_reg        <= eta;
            a_phi_reg        <= phi;
            a_is_cand_reg    <= is_candidate;
            a_has_charge_reg <= has_charge;
            a_charge_reg     <= charge;
        end
    end

    // Lepton load when a begin item leaves this stage
    always_comb
    begin
        lep_eta_next = lep_eta_reg;
        lep_phi_next = lep_phi_reg;
        if (advance && (a_func_reg == cirs_pkg::FUNC_BEGIN))
        begin
            lep_eta_next = a_eta_reg;
            lep_phi_next = a_phi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lep_eta_reg <= '0;
            lep_phi_reg <= '0;
        end
        else
        begin
            lep_eta_reg <= lep_eta_next;
            lep_phi_reg <= lep_phi_next;
        end
    end

    // Candidate selection
    always_comb
    begin
        keep = a_is_cand_reg
            && (a_pt_reg >= cfg.min_pt)
            && (a_pt_reg != '0)
            && !(cfg.charged_only && a_has_charge_reg && (a_charge_reg == '0))
            && (a_eta_reg <= cirs_pkg::ETA_MAX)
            && (a_eta_reg >= -cirs_pkg::ETA_MAX);
    end

    // Deltas, phi wrapped by one turn at most
    always_comb
    begin
        deta     = cirs_pkg::DETA_BITS'(a_eta_reg) - cirs_pkg::DETA_BITS'(lep_eta_reg);
        dphi_raw = cirs_pkg::DPHI_BITS'(a_phi_reg) - cirs_pkg::DPHI_BITS'(lep_phi_reg);
        if (dphi_raw > cirs_pkg::PHI_HALF)
        begin
            dphi = dphi_raw - cirs_pkg::DPHI_BITS'(cirs_pkg::PHI_FULL);
        end
        else if (dphi_raw < -cirs_pkg::PHI_HALF)
        begin
            dphi = dphi_raw + cirs_pkg::DPHI_BITS'(cirs_pkg::PHI_FULL);
        end
        else
        begin
            dphi = dphi_raw;
        end
    end

    // Squares and squared distance
    always_comb
    begin
        deta_w = cirs_pkg::D2_BITS'(deta);
        dphi_w = (2*cirs_pkg::DPHI_BITS)'(dphi);
        sq_eta = deta_w * deta_w;
        sq_phi = dphi_w * dphi_w;
    end

    always_comb
    begin
        geom.func = a_func_reg;
        geom.pt   = a_pt_reg;
        geom.keep = keep;
        geom.d2   = $unsigned(sq_eta) + cirs_pkg::D2_BITS'($unsigned(sq_phi));
    end

endmodule

`default_nettype wire

// ----- rtl/cirs_accum.sv -----
// Ring accumulator stage: registers the geometry result, applies begin/candidate to six
// saturating count and pt-sum accumulators, snapshots them on finish. Depends on cirs_pkg.
`default_nettype none

module cirs_accum (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             geom_valid,
    input  wire cirs_pkg::geom_t  geom,
    output logic                  take,
    input  wire logic             emit_free,
    output logic                  snap_load,
    output cirs_pkg::snap_t       snap
);

    logic                                                  b_valid_reg, b_valid_next;
    cirs_pkg::geom_t                                       b_reg;
    logic                                                  lep_ok_reg, lep_ok_next;
    logic [cirs_pkg::NUM_WIN-1:0][cirs_pkg::CNT_BITS-1:0]  counts_reg, counts_next;
    logic [cirs_pkg::NUM_WIN-1:0][cirs_pkg::SUM_BITS-1:0]  sums_reg, sums_next;
    logic                                                  b_advance;
    logic [cirs_pkg::NUM_WIN-1:0]                          hits;
    logic [cirs_pkg::SUM_BITS:0]                           sum_wide;

    // A finish waits until the serialiser can take the snapshot
    assign b_advance = b_valid_reg
                    && ((b_reg.func != cirs_pkg::FUNC_FINISH) || emit_free);
    assign take      = !b_valid_reg || b_advance;
    assign hits      = cirs_pkg::win_hits(b_reg.d2);

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (take)
        begin
            b_valid_next = geom_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && geom_valid)
        begin
            b_reg <= geom;
        end
    end

    // Accumulator update
    always_comb
    begin
        counts_next = counts_reg;
        sums_next   = sums_reg;
        lep_ok_next = lep_ok_reg;
        snap_load   = 1'b0;
        sum_wide    = '0;
        if (b_advance)
        begin
            unique case (b_reg.func)
                cirs_pkg::FUNC_BEGIN:
                begin
                    counts_next = '0;
                    sums_next   = '0;
                    lep_ok_next = (b_reg.pt >= cirs_pkg::LEP_MIN_PT);
                end
                cirs_pkg::FUNC_CAND:
                begin
                    for (int w = 0; w < cirs_pkg::NUM_WIN; w++)
                    begin
                        sum_wide = {1'b0, sums_reg[w]}
                                 + (cirs_pkg::SUM_BITS + 1)'(b_reg.pt);
                        if (b_reg.keep && hits[w])
                        begin
                            if (counts_reg[w] != cirs_pkg::CNT_MAX)
                            begin
                                counts_next[w] = counts_reg[w] + 1'b1;
                            end
                            sums_next[w] = sum_wide[cirs_pkg::SUM_BITS]
                                         ? cirs_pkg::SUM_MAX
                                         : sum_wide[cirs_pkg::SUM_BITS-1:0];
                        end
                    end
                end
                cirs_pkg::FUNC_FINISH:
                begin
                    snap_load = 1'b1;
                end
                cirs_pkg::FUNC_NONE:
                begin
                    // unused code, dropped
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
            sums_reg   <= '0;
            lep_ok_reg <= 1'b0;
        end
        else
        begin
            counts_reg <= counts_next;
            sums_reg   <= sums_next;
            lep_ok_reg <= lep_ok_next;
        end
    end

    always_comb
    begin
        snap.ok     = lep_ok_reg;
        snap.counts = counts_reg;
        snap.sums   = sums_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/cirs_emit.sv -----
// Result serialiser: holds a snapshot of the six rings and sends one window per transfer.
// Depends on cirs_pkg and cone_isolation_ring_sums_assert.svh.
`default_nettype none
`include "cone_isolation_ring_sums_assert.svh"

module cirs_emit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire cirs_pkg::snap_t                snap,
    output logic                                free,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [cirs_pkg::WIN_BITS-1:0]       window,
    output logic [cirs_pkg::CNT_BITS-1:0]       count,
    output logic [cirs_pkg::SUM_BITS-1:0]       sum_pt,
    output logic                                lepton_passed,
    output logic                                last
);

    logic                              busy_reg, busy_next;
    logic [cirs_pkg::WIN_BITS-1:0]     idx_reg, idx_next;
    cirs_pkg::snap_t                   snap_reg;
    logic                              out_xfer;
    logic                              at_last;

    assign at_last  = (idx_reg == cirs_pkg::LAST_WIN);
    assign out_xfer = busy_reg && out_ready;
    // Free now, or freed by the final transfer of this cycle
    assign free     = !busy_reg || (out_ready && at_last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (out_xfer)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            snap_reg <= snap;
        end
    end

    // Output selection; a failed lepton reads as zeros
    always_comb
    begin
        out_valid     = busy_reg;
        window        = idx_reg;
        last          = at_last;
        lepton_passed = snap_reg.ok;
        count         = snap_reg.ok ? snap_reg.counts[idx_reg] : '0;
        sum_pt        = snap_reg.ok ? snap_reg.sums[idx_reg]   : '0;
    end

    // Checks
    `CIRS_ASSERT_IMPL(a_load_only_when_free, load, free, "snapshot loaded while results pending")
    `CIRS_ASSERT_NEXT(a_load_starts_at_zero, load, busy_reg && (idx_reg == '0), "load did not restart")
    `CIRS_ASSERT_NEXT(a_stall_holds_index, busy_reg && !out_ready, busy_reg && $stable(idx_reg), "index moved under stall")
    `CIRS_ASSERT_IMPL(a_idle_index_zero, !busy_reg, idx_reg == '0, "index not parked while idle")

endmodule

`default_nettype wire

// ----- tb/cone_isolation_ring_sums_tb.sv -----
// Self-checking testbench for cone_isolation_ring_sums: directed and random items, ring sums
// predicted in the bench and compared field by field on every result transfer.
// Depends on rtl/cirs_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps

module cone_isolation_ring_sums_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;

    // Own copy of the selection and ring constants
    localparam int LEPTON_PT_MIN = 40;
    localparam int ETA_CUT       = 2560;
    localparam int PHI_WRAP_HALF = 3217;
    localparam int PHI_WRAP_FULL = 6434;
    localparam int R01_SQ = 10485;
    localparam int R02_SQ = 41943;
    localparam int R03_SQ = 94371;
    localparam int R04_SQ = 167772;
    localparam int R07_SQ = 513802;
    localparam int R08_SQ = 671088;

    typedef struct {
        cirs_pkg::func_t                          f;
        logic [cirs_pkg::PT_BITS-1:0]             pt;
        logic signed [cirs_pkg::ETA_BITS-1:0]     eta;
        logic signed [cirs_pkg::PHI_BITS-1:0]     phi;
        logic                                     is_cand;
        logic                                     has_chg;
        logic signed [cirs_pkg::CHARGE_BITS-1:0]  chg;
    } ring_item_t;

    typedef struct {
        logic [cirs_pkg::WIN_BITS-1:0] win;
        logic [cirs_pkg::CNT_BITS-1:0] cnt;
        logic [cirs_pkg::SUM_BITS-1:0] sum;
        logic                          passed;
        logic                          lst;
    } ring_result_t;

    // Clock, reset and block inputs
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] func = '0;
    logic [cirs_pkg::PT_BITS-1:0] pt = '0;
    logic signed [cirs_pkg::ETA_BITS-1:0] eta = '0;
    logic signed [cirs_pkg::PHI_BITS-1:0] phi = '0;
    logic is_candidate = 1'b0;
    logic has_charge = 1'b0;
    logic signed [cirs_pkg::CHARGE_BITS-1:0] charge = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [cirs_pkg::CFG_BITS-1:0] cfg_data = '0;

    // Block outputs
    logic in_ready;
    logic out_valid;
    logic [cirs_pkg::WIN_BITS-1:0] window;
    logic [cirs_pkg::CNT_BITS-1:0] count;
    logic [cirs_pkg::SUM_BITS-1:0] sum_pt;
    logic lepton_passed;
    logic last;

    // Shared bench state
    ring_item_t   pending_items [$];
    ring_result_t ring_expected [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  in_xfer = 1'b0;
    bit  out_xfer = 1'b0;
    bit  burst_mode = 1'b0;
    int  hold_requests = 0;

    // Predictor state and configuration copy
    logic [cirs_pkg::PT_BITS-1:0] m_min_pt = '0;
    bit                           m_charged_only = 1'b0;
    int                           m_lep_eta = 0;
    int                           m_lep_phi = 0;
    bit                           m_lep_ok = 1'b0;
    int unsigned                  ring_count [cirs_pkg::NUM_WIN];
    longint                       ring_sum   [cirs_pkg::NUM_WIN];

    // Generator view of the current lepton
    int gen_lep_eta = 0;
    int gen_lep_phi = 0;

    cone_isolation_ring_sums uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .pt            (pt),
        .eta           (eta),
        .phi           (phi),
        .is_candidate  (is_candidate),
        .has_charge    (has_charge),
        .charge        (charge),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window        (window),
        .count         (count),
        .sum_pt        (sum_pt),
        .lepton_passed (lepton_passed),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------

    // Add one candidate to a ring, both totals saturating
    task automatic add_to_ring(input int w, input int p);
        if (ring_count[w] < (1 << cirs_pkg::CNT_BITS) - 1)
            ring_count[w]++;
        ring_sum[w] += p;
        if (ring_sum[w] > (longint'(1) << cirs_pkg::SUM_BITS) - 1)
            ring_sum[w] = (longint'(1) << cirs_pkg::SUM_BITS) - 1;
    endtask

    task automatic predict_rings(input logic [1:0] f,
                                 input logic [cirs_pkg::PT_BITS-1:0] p,
                                 input logic signed [cirs_pkg::ETA_BITS-1:0] e,
                                 input logic signed [cirs_pkg::PHI_BITS-1:0] ph,
                                 input logic ic, input logic hc,
                                 input logic signed [cirs_pkg::CHARGE_BITS-1:0] ch);
        int deta;
        int dphi;
        int d2;
        ring_result_t r;
        case (cirs_pkg::func_t'(f))
            cirs_pkg::FUNC_BEGIN:
            begin
                m_lep_eta = int'(e);
                m_lep_phi = int'(ph);
                m_lep_ok  = (int'(p) >= LEPTON_PT_MIN);
                for (int k = 0; k < cirs_pkg::NUM_WIN; k++)
                begin
                    ring_count[k] = 0;
                    ring_sum[k]   = 0;
                end
            end
            cirs_pkg::FUNC_CAND:
            begin
                if (ic && p >= m_min_pt && p != 0 && !(m_charged_only && hc && ch == 0)
                    && int'(e) <= ETA_CUT && int'(e) >= -ETA_CUT)
                begin
                    deta = int'(e) - m_lep_eta;
                    dphi = int'(ph) - m_lep_phi;
                    if (dphi > PHI_WRAP_HALF)
                        dphi -= PHI_WRAP_FULL;
                    else if (dphi < -PHI_WRAP_HALF)
                        dphi += PHI_WRAP_FULL;
                    d2 = deta * deta + dphi * dphi;
                    // strict ring edges: inside r means d2 <= floor(r^2 * 2^20)
                    if (d2 <= R03_SQ) add_to_ring(0, int'(p));
                    if (d2 <= R04_SQ) add_to_ring(1, int'(p));
                    if (d2 > R03_SQ && d2 <= R07_SQ) add_to_ring(2, int'(p));
                    if (d2 > R04_SQ && d2 <= R08_SQ) add_to_ring(3, int'(p));
                    if (d2 > R01_SQ && d2 <= R08_SQ) add_to_ring(4, int'(p));
                    if (d2 > R02_SQ && d2 <= R08_SQ) add_to_ring(5, int'(p));
                end
            end
            cirs_pkg::FUNC_FINISH:
            begin
                for (int k = 0; k < cirs_pkg::NUM_WIN; k++)
                begin
                    r.win    = cirs_pkg::WIN_BITS'(k);
                    r.cnt    = m_lep_ok ? cirs_pkg::CNT_BITS'(ring_count[k]) : '0;
                    r.sum    = m_lep_ok ? cirs_pkg::SUM_BITS'(ring_sum[k]) : '0;
                    r.passed = m_lep_ok;
                    r.lst    = (k == cirs_pkg::NUM_WIN - 1);
                    ring_expected.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Input tap, result checker and cycle limit, all on the rising edge
    always @(posedge clk)
    begin : monitor
        ring_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL cone_isolation_ring_sums");
            $finish;
        end
        if (!rst_n)
        begin
            in_xfer  = 1'b0;
            out_xfer = 1'b0;
        end
        else
        begin
            in_xfer  = in_valid && in_ready;
            out_xfer = out_valid && out_ready;
            if (in_xfer)
                predict_rings(func, pt, eta, phi, is_candidate, has_charge, charge);
            if (out_xfer)
            begin
                if (ring_expected.size() == 0)
                    report_mismatch($sformatf("result for window %0d with none expected",
                                              window));
                else
                begin
                    want = ring_expected.pop_front();
                    check_field("window", window, want.win);
                    check_field("count", count, want.cnt);
                    check_field("sum_pt", sum_pt, want.sum);
                    check_field("lepton_passed", lepton_passed, want.passed);
                    check_field("last", last, want.lst);
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Driver: one item per transfer, random gap drawn per item
    // ---------------------------------------------------------------------------------

    always @(negedge clk)
    begin : driver
        ring_item_t it;
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap = 0;
        end
        else if (!in_valid || in_xfer)
        begin
            if (gap > 0)
            begin
                gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                func         <= it.f;
                pt           <= it.pt;
                eta          <= it.eta;
                phi          <= it.phi;
                is_candidate <= it.is_cand;
                has_charge   <= it.has_chg;
                charge       <= it.chg;
                in_valid     <= 1'b1;
                gap = burst_mode ? 0 : $urandom_range(0, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random wait per result, plus a long hold-off on request
    always @(negedge clk)
    begin : receiver
        int wait_left;
        int hold_left;
        int hold_served;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            wait_left = 0;
            hold_left = 0;
            hold_served = 0;
        end
        else
        begin
            if (out_xfer)
                wait_left = burst_mode ? 0 : $urandom_range(0, 6);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic queue_item(input cirs_pkg::func_t f, input int p, input int e, input int ph,
                              input bit ic, input bit hc, input int ch);
        ring_item_t it;
        it.f       = f;
        it.pt      = cirs_pkg::PT_BITS'(p);
        it.eta     = cirs_pkg::ETA_BITS'(e);
        it.phi     = cirs_pkg::PHI_BITS'(ph);
        it.is_cand = ic;
        it.has_chg = hc;
        it.chg     = cirs_pkg::CHARGE_BITS'(ch);
        pending_items.push_back(it);
    endtask

    // Item with every field random apart from the code
    task automatic queue_random_fields(input cirs_pkg::func_t f);
        queue_item(f, $urandom_range(0, 65535), rand_span(-5120, 5120),
                   rand_span(-3217, 3217), $urandom_range(0, 1), $urandom_range(0, 1),
                   rand_span(-2, 2));
    endtask

    // Radii just inside and just outside each ring edge, in 1/1024 units
    function automatic int edge_radius(input int i);
        case (i)
            0:  return 102;
            1:  return 103;
            2:  return 204;
            3:  return 205;
            4:  return 307;
            5:  return 308;
            6:  return 409;
            7:  return 410;
            8:  return 716;
            9:  return 717;
            10: return 819;
            default: return 820;
        endcase
    endfunction

    task automatic queue_lepton();
        int p;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            p = $urandom_range(0, 39);
        else if (sel == 2)
            p = 39;
        else if (sel == 3)
            p = 40;
        else
            p = $urandom_range(40, 65535);
        gen_lep_eta = ($urandom_range(0, 9) < 7) ? rand_span(-2560, 2560)
                                                 : rand_span(-5120, 5120);
        gen_lep_phi = rand_span(-3217, 3217);
        queue_item(cirs_pkg::FUNC_BEGIN, p, gen_lep_eta, gen_lep_phi, $urandom_range(0, 1),
                   $urandom_range(0, 1), rand_span(-2, 2));
    endtask

    // Candidate pt: zero, around the threshold, full scale, soft or anything
    function automatic int pick_cand_pt();
        int sel;
        int p;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return 0;
        if (sel < 25)
        begin
            p = int'(m_min_pt) + rand_span(-1, 1);
            return (p < 0) ? 0 : (p > 65535) ? 65535 : p;
        end
        if (sel < 40)
            return 65535;
        if (sel < 70)
            return $urandom_range(1, 400);
        return $urandom_range(0, 65535);
    endfunction

    // Candidate mostly placed around the lepton, on ring edges or nearby
    task automatic queue_cand();
        int deta;
        int dphi;
        int e;
        int ph;
        int ch;
        deta = 0;
        dphi = 0;
        case ($urandom_range(0, 3))
            0: deta = edge_radius($urandom_range(0, 11)) * ($urandom_range(0, 1) ? 1 : -1);
            1: dphi = edge_radius($urandom_range(0, 11)) * ($urandom_range(0, 1) ? 1 : -1);
            default:
            begin
                deta = rand_span(-900, 900);
                dphi = rand_span(-900, 900);
            end
        endcase
        e = gen_lep_eta + deta;
        if (e > 5120 || e < -5120)
            e = gen_lep_eta - deta;
        ph = gen_lep_phi + dphi;
        if (ph > PHI_WRAP_HALF)
            ph -= PHI_WRAP_FULL;
        else if (ph < -PHI_WRAP_HALF)
            ph += PHI_WRAP_FULL;
        if ($urandom_range(0, 3) == 0)
        begin
            e  = rand_span(-5120, 5120);
            ph = rand_span(-3217, 3217);
        end
        ch = ($urandom_range(0, 9) < 3) ? 0 : rand_span(-2, 2);
        queue_item(cirs_pkg::FUNC_CAND, pick_cand_pt(), e, ph, $urandom_range(0, 11) != 0,
                   $urandom_range(0, 1), ch);
    endtask

    // Mostly complete lepton sequences; stray items, open and repeated finishes as noise
    task automatic random_phase(input int n_items);
        int sent;
        int ncand;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0: queue_random_fields(cirs_pkg::FUNC_NONE);
                1:
                begin
                    queue_cand();
                    sent++;
                end
                2:
                begin
                    queue_random_fields(cirs_pkg::FUNC_FINISH);
                    sent++;
                end
                default:
                begin
                    queue_lepton();
                    ncand = $urandom_range(0, 8);
                    for (int k = 0; k < ncand; k++)
                        queue_cand();
                    sent += ncand + 1;
                    if ($urandom_range(0, 7) != 0)
                    begin
                        queue_random_fields(cirs_pkg::FUNC_FINISH);
                        sent++;
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        queue_random_fields(cirs_pkg::FUNC_FINISH);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // Sender idle, no result outstanding, pipeline given time to empty
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || ring_expected.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input cirs_pkg::cfg_idx_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cirs_pkg::CFG_BITS'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == cirs_pkg::CFG_MIN_PT)
            m_min_pt = cirs_pkg::PT_BITS'(value);
        else
            m_charged_only = value[0];
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------

    initial
    begin
        for (int k = 0; k < cirs_pkg::NUM_WIN; k++)
        begin
            ring_count[k] = 0;
            ring_sum[k]   = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_cfg(cirs_pkg::CFG_MIN_PT, 0);
        write_cfg(cirs_pkg::CFG_CHARGED_ONLY, 0);

        // Candidate before any lepton, then a finish on the reset lepton
        queue_item(cirs_pkg::FUNC_CAND, 100, 10, -10, 1, 1, 1);
        queue_item(cirs_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0);
        queue_random_fields(cirs_pkg::FUNC_NONE);
        // Lepton just under 10 GeV: rings run, results flagged failed
        queue_item(cirs_pkg::FUNC_BEGIN, 39, 0, 0, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 65535, 0, 0, 1, 1, 2);
        queue_item(cirs_pkg::FUNC_FINISH, 65535, -5120, 3217, 1, 1, -2);
        // Lepton at exactly 10 GeV on the phi edge; candidate across the wrap
        queue_item(cirs_pkg::FUNC_BEGIN, 40, 0, 3217, 0, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 65535, 0, -3217, 1, 1, -2);
        queue_item(cirs_pkg::FUNC_CAND, 0, 0, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 500, 0, 3217, 0, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 500, 2561, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 500, -2560, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 500, 5120, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 500, -5120, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 7, 50, 3200, 1, 1, 0);
        // Just inside and just outside ring edges
        queue_item(cirs_pkg::FUNC_CAND, 11, 102, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 13, 103, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 17, 0, 2910, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 19, 0, 2909, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 23, 819, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 29, 820, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 31, -716, 3217, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 37, -717, 3217, 1, 0, 0);
        // Finish twice: the second repeats the first
        queue_item(cirs_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0);
        queue_item(cirs_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // Neutral candidates rejected
        write_cfg(cirs_pkg::CFG_CHARGED_ONLY, 1);
        random_phase(25);
        wait_idle();

        // Highest threshold, no idling on either side
        write_cfg(cirs_pkg::CFG_MIN_PT, 65535);
        write_cfg(cirs_pkg::CFG_CHARGED_ONLY, 0);
        burst_mode = 1'b1;
        random_phase(15);
        wait_idle();

        // Mid threshold with a long receiver hold-off so the input backs up
        burst_mode = 1'b0;
        write_cfg(cirs_pkg::CFG_MIN_PT, rand_span(1, 2000));
        write_cfg(cirs_pkg::CFG_CHARGED_ONLY, 1);
        random_phase(35);
        hold_requests++;
        wait_idle();

        // A new lepton clears the rings again, back to back
        write_cfg(cirs_pkg::CFG_MIN_PT, 0);
        write_cfg(cirs_pkg::CFG_CHARGED_ONLY, 0);
        burst_mode = 1'b1;
        queue_item(cirs_pkg::FUNC_BEGIN, 40, 0, 0, 0, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 65535, 0, 0, 1, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 65535, 461, 0, 1, 1, 1);
        queue_item(cirs_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0);
        queue_item(cirs_pkg::FUNC_BEGIN, 1000, 100, 100, 0, 0, 0);
        queue_item(cirs_pkg::FUNC_CAND, 250, 150, 50, 1, 1, -1);
        queue_item(cirs_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0);
        wait_idle();

        if (mismatches == 0)
            $display("PASS cone_isolation_ring_sums");
        else
            $display("FAIL cone_isolation_ring_sums");
        $finish;
    end

endmodule
